[rtl/trial_division_prime_test_assert.svh]
// Assertion macros shared by the trial-division prime test RTL.
// Depends on nothing; define ASSERT_OFF to compile the checks away.
`ifndef TRIAL_DIVISION_PRIME_TEST_ASSERT_SVH
`define TRIAL_DIVISION_PRIME_TEST_ASSERT_SVH

`ifndef ASSERT_OFF
// When a holds, b must hold in the same cycle
`define TDP_ASSERT_SAME(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
    else $error("same-cycle check failed");
// When a holds, b must hold in the next cycle
`define TDP_ASSERT_NEXT(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
    else $error("next-cycle check failed");
`else
`define TDP_ASSERT_SAME(label, clk, rst_n, a, b)
`define TDP_ASSERT_NEXT(label, clk, rst_n, a, b)
`endif

`endif

[rtl/tdp_pkg.sv]
// Shared types and constants of the trial-division prime test.
// Depends on nothing.
package tdp_pkg;

  // First trial divisor and the step between odd divisors
  localparam int unsigned FIRST_DIVISOR = 3;
  localparam int unsigned DIVISOR_STEP  = 2;
  localparam int unsigned SMALLEST_PRIME = 2;
  localparam int unsigned LARGEST_NON_PRIME_LOW = 1;

  // Status from the serial remainder unit back to the controller
  typedef struct packed {
    logic done;      // one-cycle pulse: remainder is final
    logic rem_zero;  // remainder equals zero
  } tdp_rem_stat_t;

endpackage

[rtl/trial_division_prime_test.sv]
// Top level of the trial-division prime test: controller and output register.
// Depends on tdp_pkg, tdp_serial_rem and trial_division_prime_test_assert.svh.
`include "trial_division_prime_test_assert.svh"

// Takes one unsigned NUMBER_WIDTH-bit number per item and returns one item
// whose prime_flag is 1 when the number is prime. Zero, one and even numbers
// other than two are decided without a trial division. An odd number tries
// the divisors 3, 5, 7, ... while divisor squared is at most the number; each
// trial runs the bit-serial remainder unit, which takes one dividend bit per
// cycle. One item is worked on at a time; a new item is taken while the
// previous result still waits in the output register.
module trial_division_prime_test #(
  parameter int unsigned NUMBER_WIDTH = 20
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [NUMBER_WIDTH-1:0] in_number,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic                    out_prime_flag
);
  import tdp_pkg::*;

  localparam int unsigned SQW = NUMBER_WIDTH + 2;

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_CHECK  = 2'd1;
  localparam logic [1:0] S_DIV    = 2'd2;
  localparam logic [1:0] S_RESULT = 2'd3;

  logic [1:0]              state_r, state_nxt;
  logic [NUMBER_WIDTH-1:0] n_r, n_nxt;
  logic [NUMBER_WIDTH-1:0] d_r, d_nxt;
  logic [SQW-1:0]          sq_r, sq_nxt;
  logic                    flag_r, flag_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic                    out_flag_r, out_flag_nxt;
  logic                    div_start;
  tdp_rem_stat_t           rem_stat;

  tdp_serial_rem #(.W(NUMBER_WIDTH)) u_rem (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (n_r),
    .divisor  (d_r),
    .stat     (rem_stat)
  );

  // Sequence the trial divisors and hand results to the output register
  always_comb begin
    state_nxt     = state_r;
    n_nxt         = n_r;
    d_nxt         = d_r;
    sq_nxt        = sq_r;
    flag_nxt      = flag_r;
    out_flag_nxt  = out_flag_r;
    out_valid_nxt = out_valid_r && !out_ready;
    div_start     = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          n_nxt  = in_number;
          d_nxt  = NUMBER_WIDTH'(FIRST_DIVISOR);
          sq_nxt = SQW'(FIRST_DIVISOR * FIRST_DIVISOR);
          priority if (in_number <= NUMBER_WIDTH'(LARGEST_NON_PRIME_LOW)) begin
            flag_nxt  = 1'b0;
            state_nxt = S_RESULT;
          end else if (in_number == NUMBER_WIDTH'(SMALLEST_PRIME)) begin
            flag_nxt  = 1'b1;
            state_nxt = S_RESULT;
          end else if (!in_number[0]) begin
            flag_nxt  = 1'b0;
            state_nxt = S_RESULT;
          end else begin
            state_nxt = S_CHECK;
          end
        end
      end
      S_CHECK: begin
        // Stop once divisor squared passes the number
        if (sq_r > {2'b00, n_r}) begin
          flag_nxt  = 1'b1;
          state_nxt = S_RESULT;
        end else begin
          div_start = 1'b1;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        if (rem_stat.done) begin
          if (rem_stat.rem_zero) begin
            flag_nxt  = 1'b0;
            state_nxt = S_RESULT;
          end else begin
            // (d+2)^2 = d^2 + 4d + 4
            d_nxt     = d_r + NUMBER_WIDTH'(DIVISOR_STEP);
            sq_nxt    = sq_r + {d_r, 2'b00} + SQW'(4);
            state_nxt = S_CHECK;
          end
        end
      end
      S_RESULT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_flag_nxt  = flag_r;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    n_r        <= n_nxt;
    d_r        <= d_nxt;
    sq_r       <= sq_nxt;
    flag_r     <= flag_nxt;
    out_flag_r <= out_flag_nxt;
  end

  assign in_ready       = (state_r == S_IDLE);
  assign out_valid      = out_valid_r;
  assign out_prime_flag = out_flag_r;

  `TDP_ASSERT_SAME(a_done_in_div, clk, rst_n, rem_stat.done, state_r == S_DIV)
  `TDP_ASSERT_SAME(a_odd_divisor, clk, rst_n, state_r == S_DIV, d_r[0] && (d_r >= NUMBER_WIDTH'(FIRST_DIVISOR)))
  `TDP_ASSERT_SAME(a_prime_odd_or_two, clk, rst_n, (state_r == S_RESULT) && flag_r, n_r[0] || (n_r == NUMBER_WIDTH'(SMALLEST_PRIME)))

endmodule

[rtl/tdp_serial_rem.sv]
// Bit-serial restoring remainder unit: one dividend bit per cycle.
// Depends on tdp_pkg and trial_division_prime_test_assert.svh.
`include "trial_division_prime_test_assert.svh"

module tdp_serial_rem #(
  parameter int unsigned W = 20
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [W-1:0]          dividend,
  input  logic [W-1:0]          divisor,
  output tdp_pkg::tdp_rem_stat_t stat
);
  import tdp_pkg::*;

  localparam int unsigned CW = (W > 1) ? $clog2(W) : 1;

  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [W-1:0]  dvd_r, dvd_nxt;
  logic [W-1:0]  dvs_r, dvs_nxt;
  logic [W-1:0]  rem_r, rem_nxt;
  logic [W:0]    trial;
  logic          ge;

  // Shift in the next dividend bit and try one subtraction
  assign trial = {rem_r, dvd_r[W-1]};
  assign ge    = (trial >= {1'b0, dvs_r});

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    dvd_nxt  = dvd_r;
    dvs_nxt  = dvs_r;
    rem_nxt  = rem_r;
    if (start) begin
      // Load operands and clear the partial remainder
      busy_nxt = 1'b1;
      cnt_nxt  = CW'(W - 1);
      dvd_nxt  = dividend;
      dvs_nxt  = divisor;
      rem_nxt  = '0;
    end else if (busy_r) begin
      // Advance one bit
      rem_nxt = ge ? W'(trial - {1'b0, dvs_r}) : trial[W-1:0];
      dvd_nxt = {dvd_r[W-2:0], 1'b0};
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        cnt_nxt = cnt_r - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    dvd_r <= dvd_nxt;
    dvs_r <= dvs_nxt;
    rem_r <= rem_nxt;
  end

  assign stat.done     = done_r;
  assign stat.rem_zero = (rem_r == '0);

  `TDP_ASSERT_SAME(a_start_idle, clk, rst_n, start, !busy_r)
  `TDP_ASSERT_SAME(a_done_idle, clk, rst_n, done_r, !busy_r)
  `TDP_ASSERT_NEXT(a_last_bit_done, clk, rst_n, busy_r && (cnt_r == '0) && !start, done_r)

endmodule

[tb/sv/prime_flag_checker.sv]
// Checker for the trial-division prime test: watches both channels,
// predicts each prime_flag and compares it with what the block returns.
// Depends on tdp_pkg for the trial divisor constants.
module prime_flag_checker #(
  parameter int unsigned NUMBER_WIDTH = 20
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  input  logic                    in_ready,
  input  logic [NUMBER_WIDTH-1:0] in_number,
  input  logic                    out_valid,
  input  logic                    out_ready,
  input  logic                    out_prime_flag,
  output int                      fail_count,
  output int                      flags_pending
);
  timeunit 1ns;
  timeprecision 1ps;

  // Flags still owed by the block, oldest first, with the numbers behind them
  bit                    expected_flags[$];
  logic [NUMBER_WIDTH-1:0] tested_numbers[$];

  initial fail_count = 0;
  initial flags_pending = 0;

  // Trial division with the exact bound divisor * divisor <= number
  function automatic bit number_is_prime(logic [NUMBER_WIDTH-1:0] number);
    longint unsigned value;
    longint unsigned divisor;
    value = number;
    if (value < tdp_pkg::SMALLEST_PRIME) return 1'b0;
    if (value == tdp_pkg::SMALLEST_PRIME) return 1'b1;
    if (value[0] == 1'b0) return 1'b0;
    for (divisor = tdp_pkg::FIRST_DIVISOR; divisor * divisor <= value;
         divisor += tdp_pkg::DIVISOR_STEP) begin
      if (value % divisor == 0) return 1'b0;
    end
    return 1'b1;
  endfunction

  task automatic report_mismatch(input string what);
    $display("%0t ns: mismatch: %s", $time, what);
    fail_count++;
  endtask

  always @(posedge clk) begin
    if (rst_n) begin
      // Compare a returned item first, so a result never matches its own input
      if (out_valid && out_ready) begin
        if (expected_flags.size() == 0) begin
          report_mismatch($sformatf("result item with no number pending, prime_flag %b",
                                    out_prime_flag));
        end else begin
          if (out_prime_flag !== expected_flags[0]) begin
            report_mismatch($sformatf("number %0d: prime_flag %b, expected %b",
                                      tested_numbers[0], out_prime_flag,
                                      expected_flags[0]));
          end
          void'(expected_flags.pop_front());
          void'(tested_numbers.pop_front());
        end
      end
      // Predict the flag of an accepted number
      if (in_valid && in_ready) begin
        expected_flags.push_back(number_is_prime(in_number));
        tested_numbers.push_back(in_number);
      end
      // Publish how many items are still owed
      flags_pending <= expected_flags.size();
    end
  end

endmodule

[tb/sv/trial_division_prime_test_test.sv]
// Testbench top for the trial-division prime test: clock, reset, number
// stimulus with random source and sink stalls, and the final verdict.
// Depends on trial_division_prime_test and prime_flag_checker.
module trial_division_prime_test_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NUMBER_WIDTH = 20;
  localparam int unsigned NUMBER_MAX   = (1 << NUMBER_WIDTH) - 1;
  localparam int          RANDOM_ITEMS = 80;
  localparam int          QUIET_FROM   = 64;
  localparam int          DRAIN_LIMIT  = 100000;
  localparam int          SETTLE_CYCLES = 30;

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    in_valid = 1'b0;
  logic                    in_ready;
  logic [NUMBER_WIDTH-1:0] in_number = '0;
  logic                    out_valid;
  logic                    out_ready = 1'b0;
  logic                    out_prime_flag;
  int                      fail_count;
  int                      flags_pending;
  bit                      quiet = 1'b0;

  trial_division_prime_test #(.NUMBER_WIDTH(NUMBER_WIDTH)) dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_number     (in_number),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_prime_flag(out_prime_flag)
  );

  prime_flag_checker #(.NUMBER_WIDTH(NUMBER_WIDTH)) flag_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_number     (in_number),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_prime_flag(out_prime_flag),
    .fail_count    (fail_count),
    .flags_pending (flags_pending)
  );

  // 20 ns clock
  initial begin
    forever #10 clk = ~clk;
  end

  // Hard stop well beyond the slowest correct run
  initial begin
    #200_000_000;
    $display("FAIL trial_division_prime_test");
    $finish;
  end

  // Sink: drop ready in bursts, hold it high once the run goes quiet
  initial begin
    @(posedge clk iff rst_n);
    forever begin
      if (!quiet && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 5)) @(posedge clk);
      end
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  end

  // Offer one number, with an optional idle burst first; return once accepted
  task automatic send_number(input logic [NUMBER_WIDTH-1:0] number);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_number <= number;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  function automatic logic [NUMBER_WIDTH-1:0] random_number();
    int unsigned pick;
    pick = $urandom_range(0, 19);
    // Mostly small and medium numbers keep the trial loops short
    if (pick < 12) return NUMBER_WIDTH'($urandom_range(0, 1023));
    if (pick < 17) return NUMBER_WIDTH'($urandom_range(0, 65535));
    return NUMBER_WIDTH'($urandom_range(0, NUMBER_MAX));
  endfunction

  initial begin
    logic [NUMBER_WIDTH-1:0] directed_numbers[$];
    int                      waited;

    // Zero, one, two, small odd values, squares of primes, all-ones,
    // the largest even value, and large primes that run the full loop
    directed_numbers = '{0, 1, 2, 3, 4, 5, 7, 9, 15, 25, 49, 97, 121, 169, 341, 961,
                         65537, 524287, 1000003, 1042441, NUMBER_MAX - 1,
                         NUMBER_MAX - 2, NUMBER_MAX};

    // Hold reset low, then release it
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_numbers[i]) send_number(directed_numbers[i]);

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == QUIET_FROM) quiet = 1'b1;
      send_number(random_number());
    end
    quiet = 1'b1;
    in_valid <= 1'b0;

    // Drain outstanding results, then allow the block to settle
    waited = 0;
    while (flags_pending != 0) begin
      if (waited == DRAIN_LIMIT) begin
        $display("FAIL trial_division_prime_test");
        $finish;
      end
      @(posedge clk);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (fail_count == 0) begin
      $display("PASS trial_division_prime_test");
    end else begin
      $display("FAIL trial_division_prime_test");
    end
    $finish;
  end

endmodule
